// ===== rtl/array_linked_sorted_list_core_assert.svh =====
// Assertion macros shared by the sorted list core RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef ARRAY_LINKED_SORTED_LIST_CORE_ASSERT_SVH
`define ARRAY_LINKED_SORTED_LIST_CORE_ASSERT_SVH

// same-cycle implication
`define ALSL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("alsl assertion failed");

// next-cycle implication
`define ALSL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("alsl assertion failed");

`endif

// ===== rtl/alsl_pkg.sv =====
// Package for the sorted linked list core: sizes, codes and inter-module structs.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package alsl_pkg;

   localparam int NODES  = 1024;
   localparam int IDX_W  = $clog2(NODES + 1);
   localparam int ADDR_W = $clog2(NODES);
   localparam int VAL_W  = 32;

   localparam logic [IDX_W-1:0] NODES_IDX = IDX_W'(NODES);

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_FIND   = 1'b1;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   typedef struct packed {
      logic              val_we;
      logic [ADDR_W-1:0] val_addr;
      logic [VAL_W-1:0]  value;
      logic              lnk_we;
      logic [ADDR_W-1:0] lnk_addr;
      logic [IDX_W-1:0]  link;
   } mem_wr_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] node_index;
      logic [1:0]       status;
   } result_type;

   // node n (1..NODES) lives at memory address n-1
   function automatic logic [ADDR_W-1:0] node_addr(input logic [IDX_W-1:0] n);
      logic [IDX_W-1:0] m;
      m = n - IDX_W'(1);
      return m[ADDR_W-1:0];
   endfunction

endpackage

// ===== rtl/array_linked_sorted_list_core.sv =====
// Sorted linked list core, top level: mode register, sequencer, node memory, result register.
// Depends on alsl_pkg, alsl_seq, alsl_node_mem and array_linked_sorted_list_core_assert.svh.
//
// Usage:
//   Request: drive req_type (0 insert, 1 find) and req_value with start high; the item is
//   taken at a rising edge where start is high and busy is low. busy stays high while the
//   list is walked.
//   Result: rsp_valid pulses for one cycle with rsp_node_index and rsp_status (0 done,
//   1 not found, 2 full). The receiver cannot stall; every item gives exactly one result.
//   Mode: csr_we writes csr_wdata into sorted_mode (1 ascending insert, 0 head insert);
//   write only while idle.
//   Walk: head insert, full insert and find on an empty list do not walk the list. A find
//   stops at the first node equal to req_value or at the list end; a sorted insert stops
//   at the first node not less than req_value or at the list end, then splices the new node
//   in. The walk advances one node per cycle, set by the single registered read port of node
//   memory feeding the link back as the next address.
//   Reset: synchronous, active high; empties the list and selects sorted mode. Node memory
//   is not cleared; the read data of an entry is not used before it is allocated.
`timescale 1ns / 1ps
`include "array_linked_sorted_list_core_assert.svh"
module array_linked_sorted_list_core
   import alsl_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_type,
   input  logic signed [VAL_W-1:0] req_value,
   output logic                    rsp_valid,
   output logic [IDX_W-1:0]        rsp_node_index,
   output logic [1:0]              rsp_status,
   input  logic                    csr_we,
   input  logic                    csr_wdata
);

   logic                    sorted_mode_ff;
   logic                    rsp_valid_ff;
   logic [IDX_W-1:0]        rsp_node_index_ff;
   logic [1:0]              rsp_status_ff;
   result_type              done;
   mem_wr_type              mem_wr;
   logic [ADDR_W-1:0]       rd_addr;
   logic signed [VAL_W-1:0] rd_value;
   logic [IDX_W-1:0]        rd_link;

   alsl_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_type    (req_type),
      .req_value   (req_value),
      .sorted_mode (sorted_mode_ff),
      .busy        (busy),
      .done        (done),
      .mem_wr      (mem_wr),
      .rd_addr     (rd_addr),
      .rd_value    (rd_value),
      .rd_link     (rd_link)
   );

   alsl_node_mem u_node_mem (
      .clock    (clock),
      .mem_wr   (mem_wr),
      .rd_addr  (rd_addr),
      .rd_value (rd_value),
      .rd_link  (rd_link)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sorted_mode_ff <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            sorted_mode_ff <= csr_wdata;
         end
         rsp_valid_ff <= done.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (done.valid) begin
         rsp_node_index_ff <= done.node_index;
         rsp_status_ff     <= done.status;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_node_index = rsp_node_index_ff;
   assign rsp_status     = rsp_status_ff;

   `ALSL_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_valid_ff, !busy)
   `ALSL_ASSERT_NOW(a_full_zero, clock, reset, rsp_valid_ff && (rsp_status_ff == ST_FULL), rsp_node_index_ff == '0)
   `ALSL_ASSERT_NOW(a_done_nonzero, clock, reset, rsp_valid_ff && (rsp_status_ff == ST_DONE), rsp_node_index_ff != '0)

endmodule

// ===== rtl/alsl_node_mem.sv =====
// Node storage: value and link arrays, separate write ports, one shared read address.
// Depends on alsl_pkg. Read data is registered.
`timescale 1ns / 1ps
module alsl_node_mem
   import alsl_pkg::*;
(
   input  logic                    clock,
   input  mem_wr_type              mem_wr,
   input  logic [ADDR_W-1:0]       rd_addr,
   output logic signed [VAL_W-1:0] rd_value,
   output logic [IDX_W-1:0]        rd_link
);

   logic [VAL_W-1:0] values_mem [NODES];
   logic [IDX_W-1:0] links_mem  [NODES];
   logic [VAL_W-1:0] rd_value_ff;
   logic [IDX_W-1:0] rd_link_ff;

   always_ff @(posedge clock) begin
      if (mem_wr.val_we) begin
         values_mem[mem_wr.val_addr] <= mem_wr.value;
      end
      rd_value_ff <= values_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (mem_wr.lnk_we) begin
         links_mem[mem_wr.lnk_addr] <= mem_wr.link;
      end
      rd_link_ff <= links_mem[rd_addr];
   end

   assign rd_value = $signed(rd_value_ff);
   assign rd_link  = rd_link_ff;

endmodule

// ===== rtl/alsl_seq.sv =====
// Sequencer for list walks: head/count state, shared key compare, memory control.
// Depends on alsl_pkg and array_linked_sorted_list_core_assert.svh.
`timescale 1ns / 1ps
`include "array_linked_sorted_list_core_assert.svh"
module alsl_seq
   import alsl_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    req_type,
   input  logic signed [VAL_W-1:0] req_value,
   input  logic                    sorted_mode,
   output logic                    busy,
   output result_type              done,
   output mem_wr_type              mem_wr,
   output logic [ADDR_W-1:0]       rd_addr,
   input  logic signed [VAL_W-1:0] rd_value,
   input  logic [IDX_W-1:0]        rd_link
);

   typedef enum logic [3:0] {
      S_IDLE     = 4'b0001,
      S_FIND     = 4'b0010,
      S_INS_WALK = 4'b0100,
      S_SPLICE   = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        head_ff, head_in;
   logic [IDX_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        node_ff, node_in;
   logic [IDX_W-1:0]        prev_ff, prev_in;
   logic signed [VAL_W-1:0] key_ff, key_in;
   logic [IDX_W-1:0]        fresh;
   logic                    val_eq;
   logic                    val_ge;

   // shared compare unit, fed by the node just read
   assign val_eq = (rd_value == key_ff);
   assign val_ge = (rd_value >= key_ff);
   assign fresh  = count_ff + IDX_W'(1);
   assign busy   = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      count_in = count_ff;
      node_in  = node_ff;
      prev_in  = prev_ff;
      key_in   = key_ff;
      mem_wr   = '0;
      rd_addr  = node_addr(head_ff);
      done     = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               key_in  = req_value;
               node_in = head_ff;
               prev_in = '0;
               if (req_type == REQ_FIND) begin
                  if (head_ff == '0) begin
                     done.valid  = 1'b1;
                     done.status = ST_NOT_FOUND;
                  end else begin
                     state_in = S_FIND;
                  end
               end else if (count_ff == NODES_IDX) begin
                  done.valid  = 1'b1;
                  done.status = ST_FULL;
               end else begin
                  mem_wr.val_we   = 1'b1;
                  mem_wr.val_addr = count_ff[ADDR_W-1:0];
                  mem_wr.value    = req_value;
                  if (!sorted_mode || count_ff == '0) begin
                     mem_wr.lnk_we   = 1'b1;
                     mem_wr.lnk_addr = count_ff[ADDR_W-1:0];
                     mem_wr.link     = head_ff;
                     state_in        = S_SPLICE;
                  end else begin
                     state_in = S_INS_WALK;
                  end
               end
            end
         end
         S_FIND: begin
            if (val_eq) begin
               done.valid      = 1'b1;
               done.node_index = node_ff;
               done.status     = ST_DONE;
               state_in        = S_IDLE;
            end else if (rd_link == '0) begin
               done.valid  = 1'b1;
               done.status = ST_NOT_FOUND;
               state_in    = S_IDLE;
            end else begin
               node_in = rd_link;
               rd_addr = node_addr(rd_link);
            end
         end
         S_INS_WALK: begin
            if (val_ge) begin
               mem_wr.lnk_we   = 1'b1;
               mem_wr.lnk_addr = count_ff[ADDR_W-1:0];
               mem_wr.link     = node_ff;
               state_in        = S_SPLICE;
            end else if (rd_link == '0) begin
               mem_wr.lnk_we   = 1'b1;
               mem_wr.lnk_addr = count_ff[ADDR_W-1:0];
               mem_wr.link     = '0;
               prev_in         = node_ff;
               state_in        = S_SPLICE;
            end else begin
               prev_in = node_ff;
               node_in = rd_link;
               rd_addr = node_addr(rd_link);
            end
         end
         S_SPLICE: begin
            if (prev_ff == '0) begin
               head_in = fresh;
            end else begin
               mem_wr.lnk_we   = 1'b1;
               mem_wr.lnk_addr = node_addr(prev_ff);
               mem_wr.link     = fresh;
            end
            count_in        = fresh;
            done.valid      = 1'b1;
            done.node_index = fresh;
            done.status     = ST_DONE;
            state_in        = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff <= node_in;
      prev_ff <= prev_in;
      key_ff  <= key_in;
   end

   `ALSL_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= NODES_IDX)
   `ALSL_ASSERT_NOW(a_empty_head, clock, reset, 1'b1, (count_ff == '0) == (head_ff == '0))
   `ALSL_ASSERT_NEXT(a_splice_commit, clock, reset, state_ff == S_SPLICE, (count_ff == $past(count_ff) + IDX_W'(1)) && (state_ff == S_IDLE))

endmodule
